>>> sv/relr_pkg.sv
// Shared types, sizes and control structs for the RELR relocation decoder.
`default_nettype none

package relr_pkg;

   // Width of one RELR word and of the running address (32 to 64).
   localparam int ENTRY_BITS  = 64;
   // Fixed width of the address fields on the ports.
   localparam int FIELD_BITS  = 64;
   // Bytes in one word.
   localparam int WORD_BYTES  = ENTRY_BITS / 8;
   // Bitmap payload bits (bit 0 is the tag).
   localparam int BITMAP_BITS = ENTRY_BITS - 1;
   // Pointer advance after a bitmap: BITMAP_BITS words.
   localparam int BITMAP_SPAN = WORD_BYTES * BITMAP_BITS;

   typedef struct packed {
      logic [FIELD_BITS-1:0] entry;
      logic                  section_start;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] reloc_address;
      logic                  last_of_entry;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;   // capture a new item
      logic step;   // consume one bitmap position
   } relr_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic load_nonempty; // new item yields at least one address
      logic cur_bit;       // current scan position is set
      logic rest_empty;    // nothing set beyond the current position
      logic out_free;      // output register can take an item
   } relr_status_type;

endpackage

`default_nettype wire

>>> sv/relr_ctrl.sv
// Controller state machine: sequences load and scan steps.
`default_nettype none

module relr_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      busy,
   output relr_pkg::relr_cmd_type    cmd,
   input  relr_pkg::relr_status_type status
);
   import relr_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid && status.load_nonempty) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // an unset position never waits on the output
            cmd.step = !status.cur_bit || status.out_free;
            if (cmd.step && status.rest_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

>>> sv/relr_datapath.sv
// Datapath: running pointer, bitmap shifter, address counter, output register.
`default_nettype none

module relr_datapath (
   input  wire                        clock,
   input  wire                        reset,
   input  relr_pkg::req_type          req_data,
   input  wire                        rsp_stall,
   output logic                       rsp_valid,
   output relr_pkg::rsp_type          rsp_data,
   input  relr_pkg::relr_cmd_type     cmd,
   output relr_pkg::relr_status_type  status
);
   import relr_pkg::*;

   logic [ENTRY_BITS-1:0]  pointer_ff, pointer_in;
   logic [ENTRY_BITS-1:0]  addr_ff, addr_in;
   logic [BITMAP_BITS-1:0] bits_ff, bits_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [ENTRY_BITS-1:0]  word;
   logic [ENTRY_BITS-1:0]  base;
   logic [BITMAP_BITS-1:0] load_bits;
   logic                   emit;

   assign word = req_data.entry[ENTRY_BITS-1:0];
   assign base = req_data.section_start ? '0 : pointer_ff;

   // an address entry scans as a single set position
   assign load_bits = word[0] ? word[ENTRY_BITS-1:1] : BITMAP_BITS'(1);

   assign status.load_nonempty = (load_bits != '0);
   assign status.cur_bit       = bits_ff[0];
   assign status.rest_empty    = (bits_ff[BITMAP_BITS-1:1] == '0);
   assign status.out_free      = !rsp_valid_ff || !rsp_stall;

   assign emit = cmd.step && bits_ff[0];

   always_comb begin
      pointer_in = pointer_ff;
      addr_in    = addr_ff;
      bits_in    = bits_ff;
      if (cmd.load) begin
         bits_in = load_bits;
         if (word[0]) begin
            addr_in    = base;
            pointer_in = base + ENTRY_BITS'(BITMAP_SPAN);
         end else begin
            addr_in    = word;
            pointer_in = word + ENTRY_BITS'(WORD_BYTES);
         end
      end else if (cmd.step) begin
         bits_in = bits_ff >> 1;
         addr_in = addr_ff + ENTRY_BITS'(WORD_BYTES);
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.reloc_address = FIELD_BITS'(addr_ff);
         rsp_in.last_of_entry = status.rest_empty;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff   <= '0;
         bits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pointer_ff   <= pointer_in;
         bits_ff      <= bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> sv/relr_relocation_decoder.sv
// Top level of the RELR relocation decoder: controller, datapath, checks.
// Scan: an accepted item is loaded, then each set position from bit 1 up is
//   emitted into the output register; an address entry scans as bit 1 alone.
// Throughput: one scan position per cycle; an address item holds the input
//   for its one position, a bitmap item until its highest set bit, an empty
//   bitmap none. Output stalls pause the scan only on set positions.
// Reset: synchronous, active high; clears pointer, scan state, output valid.
`default_nettype none

module relr_relocation_decoder (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  relr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output relr_pkg::rsp_type rsp_data
);
   import relr_pkg::*;

   relr_cmd_type    cmd;
   relr_status_type status;
   logic            busy;

   // Controller: IDLE takes an item, SCAN walks the bitmap one bit per cycle unless a set bit waits on the output.
   relr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .busy      (busy),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath: the address item becomes a one-bit scan, so both kinds
   // share the same emit path into the output register.
   relr_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

   // Input is held off for the whole scan of an item.
   assign req_stall = busy;

`ifndef SYNTH
   // Never overwrite an output item that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && status.cur_bit) |-> status.out_free)
      else $error("output item overwritten");

   // Load and step are exclusive.
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step))
      else $error("load and step together");

   // An address entry always starts a scan that yields one item.
   a_addr_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_data.entry[0]) |=> (req_stall && status.cur_bit))
      else $error("address entry did not start a scan");

   // An address entry's item carries the end-of-entry mark.
   a_addr_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_data.entry[0]) |=> status.rest_empty)
      else $error("address entry scan not single");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_relr_relocation_decoder.sv
// Self-checking testbench for the RELR relocation decoder.
`default_nettype none

module tb_relr_relocation_decoder;
   import relr_pkg::*;

   // Run shape
   localparam int RANDOM_ITEMS  = 240;
   localparam int QUIET_FIRST   = 120;  // random items in this window run with no idling
   localparam int QUIET_LAST    = 180;
   localparam int HOLD_AT_ITEM  = 60;   // receiver starts its long hold-off here
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 100;  // extra wait once no address is still owed
   localparam int IDLE_LIMIT    = 3000; // cycles with no item moving on either side
   localparam int IDLE_PCT      = 38;
   localparam int IDX_BITS      = $clog2(FIELD_BITS);

   localparam logic [FIELD_BITS-1:0] WORD_MASK =
      (ENTRY_BITS >= FIELD_BITS) ? '1 : ((FIELD_BITS'(1) << ENTRY_BITS) - 1);

   // One directed row: the item, and the single address where it is obvious.
   typedef struct packed {
      logic [FIELD_BITS-1:0] entry;
      logic                  section_start;
      logic                  known;
      logic [FIELD_BITS-1:0] addr;
   } dir_row_type;

   // Per offered item: the typed result, if the row carries one.
   typedef struct packed {
      logic    known;
      rsp_type val;
   } note_type;

   localparam dir_row_type DIRECTED [0:21] = '{
      '{64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_0000}, // address right after reset
      '{64'h0000_0000_0000_0003, 1'b0, 1'b0, 64'h0},                   // lowest bitmap position
      '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE}, // top address, pointer wraps
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},                   // full bitmap after the wrap
      '{64'h0000_0000_0000_0001, 1'b0, 1'b0, 64'h0},                   // empty bitmap
      '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0},                   // highest position only
      '{64'h0000_0000_0000_0003, 1'b1, 1'b1, 64'h0000_0000_0000_0000}, // bitmap after section start
      '{64'h0000_0000_0000_0001, 1'b1, 1'b0, 64'h0},                   // empty bitmap, section start
      '{64'h0000_0000_0000_0005, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_1000, 1'b0, 1'b1, 64'h0000_0000_0000_1000},
      '{64'hAAAA_AAAA_AAAA_AAAB, 1'b0, 1'b0, 64'h0},
      '{64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0},
      '{64'h7FFF_FFFF_FFFF_FFF8, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFF8}, // section start on an address
      '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFF8, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFF8}, // pointer wraps to zero
      '{64'h0000_0000_0000_0003, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0002, 1'b0, 1'b1, 64'h0000_0000_0000_0002},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0},                   // 63 addresses from zero
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
      '{64'h8000_0000_0000_0000, 1'b0, 1'b1, 64'h8000_0000_0000_0000}, // top address bit
      '{64'h0000_0000_0000_0001, 1'b0, 1'b0, 64'h0},
      '{64'h0000_0000_0000_0003, 1'b0, 1'b0, 64'h0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predictor state and the addresses still owed by the block
   logic [FIELD_BITS-1:0] run_pointer = '0;
   rsp_type               decoded[$];
   rsp_type               expected_addrs[$];
   note_type              typed_notes[$];
   int                    items_in = 0;
   int                    fail_count = 0;
   bit                    quiet = 1'b0;

   relr_relocation_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Expands one RELR word into `decoded` and moves the running pointer.
   function automatic void decode_entry(input req_type item);
      logic [FIELD_BITS-1:0] word;
      logic [FIELD_BITS-1:0] offset;
      rsp_type               res;
      int                    top;
      word = item.entry & WORD_MASK;
      decoded.delete();
      if (item.section_start) run_pointer = '0;
      if (!word[0]) begin
         // address word: emit it, pointer lands one word past it
         res.reloc_address = word;
         res.last_of_entry = 1'b1;
         decoded.insert(decoded.size(), res);
         offset = FIELD_BITS'(WORD_BYTES);
         run_pointer = (word + offset) & WORD_MASK;
      end else begin
         top = 0;
         for (int k = 1; k < ENTRY_BITS; k++) if (word[IDX_BITS'(k)]) top = k;
         for (int k = 1; k < ENTRY_BITS; k++) begin
            if (word[IDX_BITS'(k)]) begin
               offset = FIELD_BITS'(WORD_BYTES * (k - 1));
               res.reloc_address = (run_pointer + offset) & WORD_MASK;
               res.last_of_entry = (k == top);
               decoded.insert(decoded.size(), res);
            end
         end
         // the pointer moves past the whole bitmap, set bits or not
         offset = FIELD_BITS'(BITMAP_SPAN);
         run_pointer = (run_pointer + offset) & WORD_MASK;
      end
   endfunction

   function automatic logic [FIELD_BITS-1:0] random_address();
      logic [FIELD_BITS-1:0] a;
      a = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) a[FIELD_BITS-1:8] = '1; // close to the wrap
      a[0] = 1'b0;
      return a;
   endfunction

   function automatic logic [FIELD_BITS-1:0] random_bitmap();
      logic [FIELD_BITS-1:0] b;
      int                    pick;
      pick = $urandom_range(0, 99);
      b = '0;
      if (pick < 45) begin
         // short scans keep many bitmaps quick
         repeat ($urandom_range(1, 4)) b[IDX_BITS'($urandom_range(1, 15))] = 1'b1;
      end else if (pick < 60) begin
         repeat ($urandom_range(1, 3))
            b[IDX_BITS'($urandom_range(1, ENTRY_BITS - 1))] = 1'b1;
      end else if (pick < 88) begin
         b = {$urandom, $urandom};
      end else if (pick >= 94) begin
         b = '1;
      end
      b[0] = 1'b1;
      return b;
   endfunction

   // Offers one item and returns at the edge where it is taken.
   task automatic send_entry(input req_type item, input logic known,
                             input logic [FIELD_BITS-1:0] known_addr);
      note_type note;
      note.known = known;
      note.val.reloc_address = known_addr;
      note.val.last_of_entry = 1'b1;
      typed_notes.insert(typed_notes.size(), note);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Receiver: random stalls, one long hold-off so the block backs up into
   // its input, and no stalls at all while the quiet window is open.
   initial begin : rsp_side
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!hold_done && items_in >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // Monitor: predict on each taken item, check each taken address.
   always @(posedge clock) begin : monitor
      rsp_type  want;
      note_type note;
      if (!reset) begin
         // results first: nothing taken at this edge can already be out
         if (rsp_valid && !rsp_stall) begin
            if (expected_addrs.size() == 0) begin
               $error("unexpected address %h (last %b)",
                      rsp_data.reloc_address, rsp_data.last_of_entry);
               fail_count++;
            end else begin
               want = expected_addrs.pop_front();
               if (rsp_data.reloc_address !== want.reloc_address) begin
                  $error("reloc_address: expected %h, got %h",
                         want.reloc_address, rsp_data.reloc_address);
                  fail_count++;
               end
               if (rsp_data.last_of_entry !== want.last_of_entry) begin
                  $error("last_of_entry: expected %b, got %b",
                         want.last_of_entry, rsp_data.last_of_entry);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            note = typed_notes.pop_front();
            decode_entry(req_data);
            if (note.known) expected_addrs.insert(expected_addrs.size(), note.val);
            else foreach (decoded[i]) expected_addrs.insert(expected_addrs.size(), decoded[i]);
            items_in <= items_in + 1;
         end
      end
   end

   // Watchdog: too long with no item moving on either side ends the run.
   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      req_type item;
      int      run_left;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         item.entry         = DIRECTED[i].entry;
         item.section_start = DIRECTED[i].section_start;
         send_entry(item, DIRECTED[i].known, DIRECTED[i].addr);
      end

      // Random runs: an address followed by a few bitmaps, as a linker lays
      // them out; now and then a run opens on a stray bitmap instead.
      run_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
         item.section_start = ($urandom_range(0, 11) == 0);
         if (run_left == 0) begin
            item.entry = ($urandom_range(0, 9) == 0) ? random_bitmap() : random_address();
            run_left   = $urandom_range(0, 4);
         end else begin
            item.entry = random_bitmap();
            run_left--;
         end
         send_entry(item, 1'b0, '0);
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      @(posedge clock);
      while (expected_addrs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_addrs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
